@@ hdl/fre_pkg.sv @@
// Shared types and constants for the four-register instruction executor.
package fre_pkg;

  typedef enum logic [3:0] {
    ACT_READ  = 4'd0,
    ACT_PRINT = 4'd1,
    ACT_MOV   = 4'd2,
    ACT_ADD   = 4'd3,
    ACT_SUB   = 4'd4,
    ACT_MUL   = 4'd5,
    ACT_DIV   = 4'd6,
    ACT_JMP   = 4'd7,
    ACT_JE    = 4'd8,
    ACT_JNE   = 4'd9,
    ACT_JG    = 4'd10,
    ACT_JGE   = 4'd11,
    ACT_JL    = 4'd12,
    ACT_JLE   = 4'd13
  } action_t;

  typedef struct packed {
    action_t            action;
    logic               src_is_reg;
    logic [1:0]         src_reg;
    logic signed [15:0] src_imm;
    logic [1:0]         dst_reg;
    logic               cmp_is_reg;
    logic [1:0]         cmp_reg;
    logic signed [15:0] cmp_imm;
    logic [7:0]         jump_target;
    logic signed [15:0] read_value;
  } instr_t;

  typedef struct packed {
    logic               print_valid;
    logic signed [15:0] print_value;
    logic [7:0]         next_pc;
    logic               div_by_zero;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic div_start; // load divider operands
    logic div_step;  // one quotient bit
    logic commit;    // write back, update pc, load result
    logic use_quot;  // write back the quotient
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;
  } status_t;

  localparam int DIV_STEPS = 16;

endpackage

@@ hdl/fre_ctrl.sv @@
// Controller state machine: request capture, divide sequencing, result slot.
module fre_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            instr_valid,
  output logic            instr_stall,
  output logic            result_valid,
  input  logic            result_stall,
  input  fre_pkg::status_t status,
  output fre_pkg::cmd_t   cmd
);
  import fre_pkg::*;

  state_t     state, state_next;
  logic [3:0] count, count_next;
  logic       slot_free;

  assign slot_free   = !result_valid || !result_stall;
  assign instr_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (instr_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.div_needed) begin
          cmd.div_start = 1'b1;
          count_next    = '0;
          state_next    = ST_DIV;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + 4'd1;
        if (count == 4'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.commit   = 1'b1;
          cmd.use_quot = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/fre_dp.sv @@
// Datapath: register file, program counter, ALU, bit-serial divider, result register.
module fre_dp #(
  parameter int PROG_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  fre_pkg::instr_t  instr,
  input  fre_pkg::cmd_t    cmd,
  output fre_pkg::status_t status,
  output fre_pkg::result_t result
);
  import fre_pkg::*;

  instr_t             ir;
  logic signed [15:0] rf [4];
  logic [7:0]         pc;

  logic signed [15:0] src, cmp, dv;
  logic signed [15:0] alu;
  logic [31:0]        prod;
  logic               wen, jump, is_div, dz;
  logic [31:0]        tmod;
  logic [7:0]         tgt;
  logic [8:0]         pc_inc;
  logic [7:0]         npc;

  // divider
  logic [15:0] rem, quo, dvsr;
  logic        neg;
  logic [16:0] shifted, diff;
  logic [15:0] quot_signed;

  assign src  = ir.src_is_reg ? rf[ir.src_reg] : ir.src_imm;
  assign cmp  = ir.cmp_is_reg ? rf[ir.cmp_reg] : ir.cmp_imm;
  assign dv   = rf[ir.dst_reg];
  assign prod = 32'(src) * 32'(dv);

  assign is_div            = (ir.action == ACT_DIV);
  assign dz                = is_div && (dv == 16'sd0);
  assign status.div_needed = is_div && (dv != 16'sd0);

  always_comb begin
    alu  = src;
    wen  = 1'b0;
    jump = 1'b0;
    unique case (ir.action)
      ACT_READ: begin alu = ir.read_value;        wen = 1'b1; end
      ACT_MOV:  begin alu = src;                  wen = 1'b1; end
      ACT_ADD:  begin alu = dv + src;             wen = 1'b1; end
      ACT_SUB:  begin alu = dv - src;             wen = 1'b1; end
      ACT_MUL:  begin alu = $signed(prod[15:0]);  wen = 1'b1; end
      ACT_JMP:  jump = 1'b1;
      ACT_JE:   jump = (src == cmp);
      ACT_JNE:  jump = (src != cmp);
      ACT_JG:   jump = (src > cmp);
      ACT_JGE:  jump = (src >= cmp);
      ACT_JL:   jump = (src < cmp);
      ACT_JLE:  jump = (src <= cmp);
      default: ;
    endcase
  end

  // Reduce the jump target modulo the program depth, one shifted subtract a bit.
  always_comb begin
    tmod = 32'(ir.jump_target);
    for (int k = 7; k >= 0; k--) begin
      if (tmod >= (32'(PROG_DEPTH) << k)) begin
        tmod = tmod - (32'(PROG_DEPTH) << k);
      end
    end
    tgt = tmod[7:0];
  end

  assign pc_inc = {1'b0, pc} + 9'd1;

  always_comb begin
    if (jump) begin
      npc = tgt;
    end else if (17'(pc_inc) >= 17'(PROG_DEPTH)) begin
      npc = '0;
    end else begin
      npc = pc_inc[7:0];
    end
  end

  assign shifted     = {rem, quo[15]};
  assign diff        = shifted - {1'b0, dvsr};
  assign quot_signed = neg ? (16'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ir <= instr;
    end
    if (cmd.div_start) begin
      rem  <= '0;
      quo  <= src[15] ? (16'd0 - src) : src;
      dvsr <= dv[15] ? (16'd0 - dv) : dv;
      neg  <= src[15] ^ dv[15];
    end else if (cmd.div_step) begin
      if (!diff[16]) begin
        rem <= diff[15:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= shifted[15:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      result.print_valid <= (ir.action == ACT_PRINT);
      result.print_value <= (ir.action == ACT_PRINT) ? src : 16'sd0;
      result.next_pc     <= npc;
      result.div_by_zero <= dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rf[i] <= '0;
      end
      pc <= '0;
    end else if (cmd.commit) begin
      pc <= npc;
      if (cmd.use_quot) begin
        rf[ir.dst_reg] <= $signed(quot_signed);
      end else if (wen) begin
        rf[ir.dst_reg] <= alu;
      end
    end
  end

endmodule

@@ hdl/four_register_instruction_executor.sv @@
// Top level of the four-register instruction executor.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-----------------------
//   request  | instr_valid   | instr_stall   | instr  (fre_pkg::instr_t)
//   result   | result_valid  | result_stall  | result (fre_pkg::result_t)
//
// A result is loaded in the execute state, once the output register is free, and the next
// request is taken in the idle state after it; a div with a non-zero divisor first runs
// the one-bit-a-cycle divider (16 steps) and loads its result in the finish state.
// Synchronous reset clears the registers, the pc and the result valid flag.
// A finished result waits in the output register while the next request is taken;
// write-back and pc update hold until the output register is free.
module four_register_instruction_executor #(
  parameter int PROG_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  fre_pkg::instr_t  instr,
  output logic             result_valid,
  input  logic             result_stall,
  output fre_pkg::result_t result
);
  import fre_pkg::*;

  cmd_t    cmd;
  status_t status;

  fre_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  fre_dp #(
    .PROG_DEPTH (PROG_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the four-register instruction executor.
module tb;
  import fre_pkg::*;

  localparam int PROG_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF     = 400;

  // opcodes outside the enum act as no-ops
  localparam logic [3:0] ACT_NOP_LO = 4'd14;
  localparam logic [3:0] ACT_NOP_HI = 4'd15;

  localparam logic [1:0] REG_AX = 2'd0;
  localparam logic [1:0] REG_BX = 2'd1;
  localparam logic [1:0] REG_CX = 2'd2;
  localparam logic [1:0] REG_DX = 2'd3;

  localparam logic OPND_IMM = 1'b0;
  localparam logic OPND_REG = 1'b1;

  class exec_scoreboard;
    logic [15:0] gpr [4];
    logic [7:0]  pc;
    result_t     due_results [$];
    int          errors;
    int          checked;

    function new();
      foreach (gpr[k]) gpr[k] = '0;
      pc      = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function logic [15:0] operand(logic is_reg, logic [1:0] idx, logic [15:0] imm);
      return is_reg ? gpr[idx] : imm;
    endfunction

    // Execute one accepted request on the shadow state and queue its result.
    function void execute_accepted(instr_t r);
      logic signed [15:0] src;
      logic signed [15:0] cmp;
      logic signed [15:0] dval;
      logic               taken;
      int                 quot;
      int                 npc;
      result_t            res;
      src   = operand(r.src_is_reg, r.src_reg, r.src_imm);
      cmp   = operand(r.cmp_is_reg, r.cmp_reg, r.cmp_imm);
      dval  = gpr[r.dst_reg];
      taken = 1'b0;
      res   = '0;
      case (r.action)
        ACT_READ:  gpr[r.dst_reg] = r.read_value;
        ACT_PRINT: begin
          res.print_valid = 1'b1;
          res.print_value = src;
        end
        ACT_MOV:   gpr[r.dst_reg] = src;
        ACT_ADD:   gpr[r.dst_reg] = dval + src;
        ACT_SUB:   gpr[r.dst_reg] = dval - src;
        ACT_MUL:   gpr[r.dst_reg] = dval * src;
        ACT_DIV: begin
          if (dval == 16'sd0) begin
            res.div_by_zero = 1'b1;
          end else begin
            // widen first so that the most negative over minus one wraps here
            quot = int'(src) / int'(dval);
            gpr[r.dst_reg] = quot[15:0];
          end
        end
        ACT_JMP:   taken = 1'b1;
        ACT_JE:    taken = (src == cmp);
        ACT_JNE:   taken = (src != cmp);
        ACT_JG:    taken = (src > cmp);
        ACT_JGE:   taken = (src >= cmp);
        ACT_JL:    taken = (src < cmp);
        ACT_JLE:   taken = (src <= cmp);
        default: ;
      endcase
      if (taken) begin
        npc = int'(r.jump_target) % PROG_DEPTH;
      end else begin
        npc = int'(pc) + 1;
        if (npc >= PROG_DEPTH) npc = 0;
      end
      pc = npc[7:0];
      res.next_pc = pc;
      due_results.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.print_valid !== want.print_valid)
        report($sformatf("print_valid %b, want %b", got.print_valid, want.print_valid));
      if (got.print_value !== want.print_value)
        report($sformatf("print_value %h, want %h", got.print_value, want.print_value));
      if (got.next_pc !== want.next_pc)
        report($sformatf("next_pc %0d, want %0d", got.next_pc, want.next_pc));
      if (got.div_by_zero !== want.div_by_zero)
        report($sformatf("div_by_zero %b, want %b", got.div_by_zero, want.div_by_zero));
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    instr_valid;
  logic    instr_stall;
  instr_t  instr;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  exec_scoreboard sb = new();

  four_register_instruction_executor #(
    .PROG_DEPTH(PROG_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] random_word();
    logic [15:0] corner [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    if ($urandom_range(0, 5) == 0) return corner[$urandom_range(0, 4)];
    return 16'($urandom);
  endfunction

  function automatic instr_t make_op(logic [3:0] act, logic sri, logic [1:0] sr,
                                     logic [15:0] simm, logic [1:0] dr, logic cri,
                                     logic [1:0] cr, logic [15:0] cimm,
                                     logic [7:0] tgt, logic [15:0] rv);
    instr_t r;
    r.action      = action_t'(act);
    r.src_is_reg  = sri;
    r.src_reg     = sr;
    r.src_imm     = simm;
    r.dst_reg     = dr;
    r.cmp_is_reg  = cri;
    r.cmp_reg     = cr;
    r.cmp_imm     = cimm;
    r.jump_target = tgt;
    r.read_value  = rv;
    return r;
  endfunction

  function automatic instr_t random_instr();
    return make_op(4'($urandom_range(0, 15)), 1'($urandom), 2'($urandom), random_word(),
                   2'($urandom), 1'($urandom), 2'($urandom), random_word(),
                   8'($urandom), random_word());
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  task offer(instr_t r, int gap);
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr       <= r;
    instr_valid <= 1'b1;
    do @(posedge clk); while (instr_stall !== 1'b0);
    sb.execute_accepted(r);
  endtask

  always @(posedge clk) begin
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0)
      sb.check_result(result);
  end

  initial begin : result_side
    int  hold_len;
    int  run_len;
    bit  held_off;
    held_off = 1'b0;
    result_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      // one long hold-off mid-run so that the block fills and stalls requests
      if (!held_off && sb.checked >= 400) begin
        held_off = 1'b1;
        hold_len = HOLD_OFF;
      end else begin
        hold_len = idle_cycles();
      end
      if (hold_len > 0) begin
        result_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
      result_stall <= 1'b0;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
    end
  end

  initial begin : stimulus
    int n;
    int gap;
    rst         <= 1'b1;
    instr_valid <= 1'b0;
    instr       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // extremes, wrap-around arithmetic and the divider corners
    offer(make_op(ACT_READ, OPND_IMM, REG_AX, 0, REG_AX, OPND_IMM, REG_AX, 0, 0, 16'h7FFF),
          idle_cycles());
    offer(make_op(ACT_READ, OPND_IMM, REG_AX, 0, REG_BX, OPND_IMM, REG_AX, 0, 0, 16'h8000),
          idle_cycles());
    offer(make_op(ACT_READ, OPND_IMM, REG_AX, 0, REG_CX, OPND_IMM, REG_AX, 0, 0, 16'hFFFF),
          idle_cycles());
    offer(make_op(ACT_PRINT, OPND_REG, REG_AX, 0, REG_DX, OPND_IMM, REG_AX, 0, 0, 0), 0);
    offer(make_op(ACT_PRINT, OPND_IMM, REG_DX, 16'h8000, REG_DX, OPND_REG, REG_AX, 0, 0, 0),
          0);
    offer(make_op(ACT_ADD, OPND_IMM, REG_AX, 16'h0001, REG_AX, OPND_IMM, REG_AX, 0, 0, 0),
          idle_cycles());
    offer(make_op(ACT_SUB, OPND_IMM, REG_AX, 16'h0001, REG_BX, OPND_IMM, REG_AX, 0, 0, 0),
          0);
    offer(make_op(ACT_MUL, OPND_REG, REG_AX, 0, REG_CX, OPND_IMM, REG_AX, 0, 0, 0), 0);
    offer(make_op(ACT_MOV, OPND_IMM, REG_AX, 16'h0000, REG_DX, OPND_IMM, REG_AX, 0, 0, 0),
          0);
    offer(make_op(ACT_DIV, OPND_IMM, REG_AX, 16'h0005, REG_DX, OPND_IMM, REG_AX, 0, 0, 0),
          idle_cycles());
    offer(make_op(ACT_READ, OPND_IMM, REG_AX, 0, REG_CX, OPND_IMM, REG_AX, 0, 0, 16'hFFFF),
          0);
    offer(make_op(ACT_DIV, OPND_REG, REG_AX, 0, REG_CX, OPND_IMM, REG_AX, 0, 0, 0), 0);
    offer(make_op(ACT_READ, OPND_IMM, REG_AX, 0, REG_DX, OPND_IMM, REG_AX, 0, 0, 16'hFFF9),
          idle_cycles());
    offer(make_op(ACT_DIV, OPND_IMM, REG_AX, 16'd100, REG_DX, OPND_IMM, REG_AX, 0, 0, 0),
          0);
    offer(make_op(ACT_DIV, OPND_IMM, REG_AX, 16'hFF9C, REG_DX, OPND_IMM, REG_AX, 0, 0, 0),
          0);
    // jump to the last slot so that the following no-op wraps the pc
    offer(make_op(ACT_JMP, OPND_IMM, REG_AX, 0, REG_AX, OPND_IMM, REG_AX, 0, 8'hFF, 0), 0);
    offer(make_op(ACT_NOP_LO, OPND_REG, REG_BX, 0, REG_CX, OPND_REG, REG_DX, 0, 8'h11, 0),
          idle_cycles());
    offer(make_op(ACT_NOP_HI, OPND_IMM, REG_AX, 0, REG_AX, OPND_IMM, REG_AX, 0, 8'h22, 0),
          0);
    offer(make_op(ACT_JE, OPND_REG, REG_AX, 0, REG_AX, OPND_REG, REG_AX, 0, 8'd10, 0), 0);
    offer(make_op(ACT_JNE, OPND_IMM, REG_AX, 0, REG_AX, OPND_IMM, REG_AX, 0, 8'd20, 0),
          idle_cycles());
    offer(make_op(ACT_JG, OPND_IMM, REG_AX, 16'h7FFF, REG_AX, OPND_IMM, REG_AX, 16'h8000,
                  8'd30, 0), 0);
    offer(make_op(ACT_JGE, OPND_IMM, REG_AX, 16'h0005, REG_AX, OPND_IMM, REG_AX, 16'h0005,
                  8'd40, 0), 0);
    offer(make_op(ACT_JL, OPND_REG, REG_BX, 0, REG_AX, OPND_IMM, REG_AX, 16'h8000,
                  8'd50, 0), idle_cycles());
    offer(make_op(ACT_JLE, OPND_IMM, REG_AX, 16'h8000, REG_AX, OPND_REG, REG_BX, 0,
                  8'd60, 0), 0);
    offer(make_op(ACT_JG, OPND_IMM, REG_AX, 16'hFFFF, REG_AX, OPND_IMM, REG_AX, 16'h0000,
                  8'd70, 0), 0);

    // random instruction streams, with back-to-back stretches
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      gap = ((n % 200) < 60) ? 0 : idle_cycles();
      offer(random_instr(), gap);
    end
    instr_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still outstanding at the end");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
